// ===== sv/ias_pkg.sv =====
// ----------------------------------------------------------------------------
// ias_pkg
// Shared widths, codes and entry types of the integer alias-table sampler.
// ----------------------------------------------------------------------------
package ias_pkg;

    localparam int MAX_OUTCOMES = 1024;
    localparam int IDX_W        = $clog2(MAX_OUTCOMES);
    localparam int CNT_W        = $clog2(MAX_OUTCOMES + 1);
    localparam int WEIGHT_W     = 32;
    localparam int SHARE_W      = 31;
    localparam int TOT_W        = WEIGHT_W + IDX_W;
    localparam int DVD_W        = WEIGHT_W + SHARE_W;
    localparam int OUTCOME_W    = 10;

    localparam logic [SHARE_W-1:0] FULL_MASS = 31'h7fffffff;

    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK      = 2'd0;
    localparam status_t STATUS_ZERO    = 2'd1;
    localparam status_t STATUS_NOTABLE = 2'd2;

    typedef struct packed {
        logic [IDX_W-1:0]   cell_idx;
        logic [SHARE_W-1:0] share;
    } qentry_t;

    typedef struct packed {
        logic [IDX_W-1:0]   alias_cell;
        logic [SHARE_W-1:0] bound;
    } aentry_t;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
        if (p == IDX_W'(MAX_OUTCOMES - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

endpackage

// ===== sv/integer_alias_table_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// integer_alias_table_sampler_unit
// Loads weights, builds an integer alias table and draws samples from it.
//
//  channel  dir  tdata                                tuser        tlast
//  s_       in   [31:0] weight, [63:32] random_draw   kind         last_weight
//  m_       out  [9:0] outcome, zero filled           status       -
//
// A sample uses the shared one-bit-per-cycle divider to form draw / height.
// A build passes each share through the same divider, then runs the
// classification, pairing and drain passes, each with a read state and a
// write state per memory read. Reset is synchronous and clears the control
// state only. A finished word waits in the output register while the next
// word is taken.
// ----------------------------------------------------------------------------
module integer_alias_table_sampler_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // weight, random_draw
    input  logic        s_tuser,   // kind
    input  logic        s_tlast,   // last_weight
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // outcome, zero filled
    output logic [1:0]  m_tuser    // status
);
    import ias_pkg::*;

    localparam int QE_W = IDX_W + SHARE_W;

    typedef enum logic [16:0] {
        ST_IDLE    = 17'b00000000000000001,
        ST_BCHECK  = 17'b00000000000000010,
        ST_BHDIV   = 17'b00000000000000100,
        ST_BMASS   = 17'b00000000000001000,
        ST_BRDW    = 17'b00000000000010000,
        ST_BMUL    = 17'b00000000000100000,
        ST_BSST    = 17'b00000000001000000,
        ST_BSDIV   = 17'b00000000010000000,
        ST_CLSRD   = 17'b00000000100000000,
        ST_CLSWR   = 17'b00000001000000000,
        ST_PAIRRD  = 17'b00000010000000000,
        ST_PAIRWR  = 17'b00000100000000000,
        ST_DRNRD   = 17'b00001000000000000,
        ST_DRNWR   = 17'b00010000000000000,
        ST_SDIV    = 17'b00100000000000000,
        ST_SRD     = 17'b01000000000000000,
        ST_EMIT    = 17'b10000000000000000
    } state_t;

    function automatic logic [SHARE_W-1:0] cell_bound(input logic [IDX_W-1:0] c,
                                                      input logic [SHARE_W-1:0] hh,
                                                      input logic [SHARE_W-1:0] s);
        logic [IDX_W+SHARE_W-1:0] p;
        p = c * hh;
        return p[SHARE_W-1:0] + s;
    endfunction

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [TOT_W-1:0]       total_reg, total_next;
    logic                   ready_reg, ready_next;
    logic                   closed_reg, closed_next;
    logic [SHARE_W-1:0]     h_reg, h_next;
    logic [SHARE_W-1:0]     m_reg, m_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [WEIGHT_W-1:0]    sum_reg, sum_next;
    logic [SHARE_W-1:0]     short_reg, short_next;
    logic [DVD_W-1:0]       prod_reg, prod_next;
    logic [WEIGHT_W-1:0]    draw_reg, draw_next;
    logic [IDX_W-1:0]       sidx_reg, sidx_next;
    logic [IDX_W-1:0]       sh_reg, sh_next, st_reg, st_next;
    logic [IDX_W-1:0]       lh_reg, lh_next, lt_reg, lt_next;
    logic [CNT_W-1:0]       sc_reg, sc_next, lc_reg, lc_next;
    logic                   dsel_reg, dsel_next;
    logic [IDX_W-1:0]       res_out_reg, res_out_next;
    status_t                res_st_reg, res_st_next;
    logic                   out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]       out_out_reg, out_out_next;
    status_t                out_st_reg, out_st_next;

    logic                   w_we;
    logic [IDX_W-1:0]       w_waddr, w_raddr;
    logic [WEIGHT_W-1:0]    w_wdata, w_rd;
    logic                   sq_we, lq_we;
    logic [IDX_W-1:0]       sq_waddr, lq_waddr;
    qentry_t                sq_wdata, lq_wdata;
    logic [QE_W-1:0]        sq_rd, lq_rd;
    logic                   a_we;
    logic [IDX_W-1:0]       a_waddr, a_raddr;
    aentry_t                a_wdata;
    logic [QE_W-1:0]        a_rd;

    logic                   div_start, div_done;
    logic [DVD_W-1:0]       div_dvd;
    logic [TOT_W-1:0]       div_dvs;
    logic [SHARE_W-1:0]     div_q;

    logic                   accept;
    logic [CNT_W-1:0]       cnt_base;
    logic [TOT_W-1:0]       tot_base;
    logic [CNT_W+SHARE_W-1:0] mass;
    qentry_t                lo, hi, back, de, ce;
    aentry_t                ae, ar;
    logic [WEIGHT_W-1:0]    tot;
    logic                   bonus;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        ready_next     = ready_reg;
        closed_next    = closed_reg;
        h_next         = h_reg;
        m_next         = m_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        short_next     = short_reg;
        prod_next      = prod_reg;
        draw_next      = draw_reg;
        sidx_next      = sidx_reg;
        sh_next        = sh_reg;
        st_next        = st_reg;
        lh_next        = lh_reg;
        lt_next        = lt_reg;
        sc_next        = sc_reg;
        lc_next        = lc_reg;
        dsel_next      = dsel_reg;
        res_out_next   = res_out_reg;
        res_st_next    = res_st_reg;
        out_out_next   = out_out_reg;
        out_st_next    = out_st_reg;
        out_valid_next = out_valid_reg && !m_tready;

        w_we      = 1'b0;
        w_waddr   = count_reg[IDX_W-1:0];
        w_wdata   = s_tdata[31:0];
        w_raddr   = idx_reg[IDX_W-1:0];
        sq_we     = 1'b0;
        lq_we     = 1'b0;
        sq_waddr  = st_reg;
        lq_waddr  = lt_reg;
        a_we      = 1'b0;
        a_raddr   = sidx_reg;
        div_start = 1'b0;
        div_dvd   = prod_reg;
        div_dvs   = total_reg;

        cnt_base = closed_reg ? '0 : count_reg;
        tot_base = closed_reg ? '0 : total_reg;
        mass     = h_reg * count_reg;

        lo    = qentry_t'(sq_rd);
        hi    = qentry_t'(lq_rd);
        ar    = aentry_t'(a_rd);
        tot   = {1'b0, hi.share} + {1'b0, lo.share};
        back.cell_idx = hi.cell_idx;
        back.share    = SHARE_W'(tot - {1'b0, h_reg});
        de    = dsel_reg ? hi : lo;
        bonus = ({{(SHARE_W-CNT_W){1'b0}}, idx_reg} < short_reg);
        ce.cell_idx = idx_reg[IDX_W-1:0];
        ce.share    = w_rd[SHARE_W-1:0] + {{(SHARE_W-1){1'b0}}, bonus};
        sq_wdata = ce;
        lq_wdata = ce;
        a_waddr  = de.cell_idx;
        ae.alias_cell = de.cell_idx;
        ae.bound      = cell_bound(de.cell_idx, h_reg, de.share);

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!s_tuser) begin
                        closed_next = 1'b0;
                        count_next  = cnt_base;
                        total_next  = tot_base;
                        if (closed_reg) begin
                            ready_next = 1'b0;
                        end
                        if (cnt_base < CNT_W'(MAX_OUTCOMES)) begin
                            w_we       = 1'b1;
                            w_waddr    = cnt_base[IDX_W-1:0];
                            count_next = cnt_base + 1'b1;
                            total_next = tot_base + TOT_W'(s_tdata[31:0]);
                        end
                        if (s_tlast) begin
                            state_next = ST_BCHECK;
                        end
                    end else if (!ready_reg) begin
                        res_out_next = '0;
                        res_st_next  = STATUS_NOTABLE;
                        state_next   = ST_EMIT;
                    end else begin
                        draw_next  = s_tdata[63:32];
                        div_start  = 1'b1;
                        div_dvd    = DVD_W'(s_tdata[63:32]);
                        div_dvs    = TOT_W'(h_reg);
                        state_next = ST_SDIV;
                    end
                end
            end
            ST_BCHECK: begin
                closed_next = 1'b1;
                ready_next  = 1'b0;
                if (total_reg == '0) begin
                    res_out_next = '0;
                    res_st_next  = STATUS_ZERO;
                    state_next   = ST_EMIT;
                end else begin
                    div_start  = 1'b1;
                    div_dvd    = DVD_W'(FULL_MASS);
                    div_dvs    = TOT_W'(count_reg);
                    state_next = ST_BHDIV;
                end
            end
            ST_BHDIV: begin
                if (div_done) begin
                    h_next     = div_q;
                    state_next = ST_BMASS;
                end
            end
            ST_BMASS: begin
                m_next     = mass[SHARE_W-1:0];
                idx_next   = '0;
                sum_next   = '0;
                state_next = ST_BRDW;
            end
            ST_BRDW: begin
                state_next = ST_BMUL;
            end
            ST_BMUL: begin
                prod_next  = w_rd * m_reg;
                state_next = ST_BSST;
            end
            ST_BSST: begin
                div_start  = 1'b1;
                state_next = ST_BSDIV;
            end
            ST_BSDIV: begin
                if (div_done) begin
                    w_we     = 1'b1;
                    w_waddr  = idx_reg[IDX_W-1:0];
                    w_wdata  = WEIGHT_W'(div_q);
                    sum_next = sum_reg + WEIGHT_W'(div_q);
                    idx_next = idx_reg + 1'b1;
                    if (idx_next == count_reg) begin
                        short_next = SHARE_W'(WEIGHT_W'(m_reg) - sum_next);
                        idx_next   = '0;
                        sh_next    = '0;
                        st_next    = '0;
                        lh_next    = '0;
                        lt_next    = '0;
                        sc_next    = '0;
                        lc_next    = '0;
                        state_next = ST_CLSRD;
                    end else begin
                        state_next = ST_BRDW;
                    end
                end
            end
            ST_CLSRD: begin
                state_next = ST_CLSWR;
            end
            ST_CLSWR: begin
                if (ce.share < h_reg) begin
                    sq_we   = 1'b1;
                    st_next = wrap_inc(st_reg);
                    sc_next = sc_reg + 1'b1;
                end else begin
                    lq_we   = 1'b1;
                    lt_next = wrap_inc(lt_reg);
                    lc_next = lc_reg + 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_next == count_reg) begin
                    state_next = ST_PAIRRD;
                end else begin
                    state_next = ST_CLSRD;
                end
            end
            ST_PAIRRD: begin
                if (sc_reg == '0 || lc_reg == '0) begin
                    state_next = ST_DRNRD;
                end else begin
                    state_next = ST_PAIRWR;
                end
            end
            ST_PAIRWR: begin
                a_we          = 1'b1;
                a_waddr       = lo.cell_idx;
                ae.alias_cell = hi.cell_idx;
                ae.bound      = cell_bound(lo.cell_idx, h_reg, lo.share);
                sh_next       = wrap_inc(sh_reg);
                lh_next       = wrap_inc(lh_reg);
                sq_wdata      = back;
                lq_wdata      = back;
                if (tot > {h_reg, 1'b0}) begin
                    lq_we   = 1'b1;
                    lt_next = wrap_inc(lt_reg);
                    sc_next = sc_reg - 1'b1;
                end else begin
                    sq_we   = 1'b1;
                    st_next = wrap_inc(st_reg);
                    lc_next = lc_reg - 1'b1;
                end
                state_next = ST_PAIRRD;
            end
            ST_DRNRD: begin
                if (sc_reg != '0) begin
                    dsel_next  = 1'b0;
                    state_next = ST_DRNWR;
                end else if (lc_reg != '0) begin
                    dsel_next  = 1'b1;
                    state_next = ST_DRNWR;
                end else begin
                    ready_next   = 1'b1;
                    res_out_next = '0;
                    res_st_next  = STATUS_OK;
                    state_next   = ST_EMIT;
                end
            end
            ST_DRNWR: begin
                a_we = 1'b1;
                if (dsel_reg) begin
                    lh_next = wrap_inc(lh_reg);
                    lc_next = lc_reg - 1'b1;
                end else begin
                    sh_next = wrap_inc(sh_reg);
                    sc_next = sc_reg - 1'b1;
                end
                state_next = ST_DRNRD;
            end
            ST_SDIV: begin
                if (div_done) begin
                    if ({{(WEIGHT_W-SHARE_W){1'b0}}, div_q} >=
                        {{(WEIGHT_W-CNT_W){1'b0}}, count_reg}) begin
                        sidx_next = IDX_W'(count_reg - 1'b1);
                    end else begin
                        sidx_next = div_q[IDX_W-1:0];
                    end
                    a_raddr    = sidx_next;
                    state_next = ST_SRD;
                end
            end
            ST_SRD: begin
                if (draw_reg < {1'b0, ar.bound}) begin
                    res_out_next = sidx_reg;
                end else begin
                    res_out_next = ar.alias_cell;
                end
                res_st_next = STATUS_OK;
                state_next  = ST_EMIT;
            end
            ST_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_out_next   = res_out_reg;
                    out_st_next    = res_st_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        a_wdata = ae;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            ready_reg     <= 1'b0;
            closed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            h_reg         <= '0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            ready_reg     <= ready_next;
            closed_reg    <= closed_next;
            out_valid_reg <= out_valid_next;
            h_reg         <= h_next;
        end
        m_reg       <= m_next;
        idx_reg     <= idx_next;
        sum_reg     <= sum_next;
        short_reg   <= short_next;
        prod_reg    <= prod_next;
        draw_reg    <= draw_next;
        sidx_reg    <= sidx_next;
        sh_reg      <= sh_next;
        st_reg      <= st_next;
        lh_reg      <= lh_next;
        lt_reg      <= lt_next;
        sc_reg      <= sc_next;
        lc_reg      <= lc_next;
        dsel_reg    <= dsel_next;
        res_out_reg <= res_out_next;
        res_st_reg  <= res_st_next;
        out_out_reg <= out_out_next;
        out_st_reg  <= out_st_next;
    end

    ias_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    ias_ram #(.WIDTH(WEIGHT_W), .DEPTH(MAX_OUTCOMES)) u_weight_ram (
        .aclk    (aclk),
        .wr_en   (w_we),
        .wr_addr (w_waddr),
        .wr_data (w_wdata),
        .rd_addr (w_raddr),
        .rd_data (w_rd)
    );

    ias_ram #(.WIDTH(QE_W), .DEPTH(MAX_OUTCOMES)) u_small_ram (
        .aclk    (aclk),
        .wr_en   (sq_we),
        .wr_addr (sq_waddr),
        .wr_data (sq_wdata),
        .rd_addr (sh_reg),
        .rd_data (sq_rd)
    );

    ias_ram #(.WIDTH(QE_W), .DEPTH(MAX_OUTCOMES)) u_large_ram (
        .aclk    (aclk),
        .wr_en   (lq_we),
        .wr_addr (lq_waddr),
        .wr_data (lq_wdata),
        .rd_addr (lh_reg),
        .rd_data (lq_rd)
    );

    ias_ram #(.WIDTH(QE_W), .DEPTH(MAX_OUTCOMES)) u_alias_ram (
        .aclk    (aclk),
        .wr_en   (a_we),
        .wr_addr (a_waddr),
        .wr_data (a_wdata),
        .rd_addr (a_raddr),
        .rd_data (a_rd)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = 16'(OUTCOME_W'(out_out_reg));
    assign m_tuser  = out_st_reg;

endmodule

// ===== sv/ias_ram.sv =====
// ----------------------------------------------------------------------------
// ias_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ias_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== sv/ias_div.sv =====
// ----------------------------------------------------------------------------
// ias_div
// Restoring divider, one quotient bit per cycle. The upper part of the
// dividend must be below the divisor, so the quotient fits its width.
// ----------------------------------------------------------------------------
module ias_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ias_pkg::DVD_W-1:0]     dividend,
    input  logic [ias_pkg::TOT_W-1:0]     divisor,
    output logic                          done,
    output logic [ias_pkg::SHARE_W-1:0]   quotient
);
    import ias_pkg::*;

    localparam int STEP_W = $clog2(SHARE_W + 1);

    logic [TOT_W-1:0]   rem_reg, rem_next;
    logic [SHARE_W-1:0] low_reg, low_next;
    logic [SHARE_W-1:0] q_reg, q_next;
    logic [TOT_W-1:0]   div_reg, div_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [TOT_W:0]     trial;

    always_comb begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, low_reg[SHARE_W-1]};
        if (start) begin
            rem_next  = TOT_W'(dividend[DVD_W-1:SHARE_W]);
            low_next  = dividend[SHARE_W-1:0];
            div_next  = divisor;
            cnt_next  = STEP_W'(SHARE_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            low_next = {low_reg[SHARE_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg}) begin
                rem_next = TOT_W'(trial - {1'b0, div_reg});
                q_next   = {q_reg[SHARE_W-2:0], 1'b1};
            end else begin
                rem_next = trial[TOT_W-1:0];
                q_next   = {q_reg[SHARE_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        low_reg <= low_next;
        q_reg   <= q_next;
        div_reg <= div_next;
        cnt_reg <= cnt_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== sim/alias_sampler_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alias_sampler_checker
// Watches both channels of the alias-table sampler. Every accepted input word
// is run through a behavioural copy of the sampler, which forms an expected
// output word for each sample and last weight; every accepted output word is
// compared field by field with the oldest expected word.
// ----------------------------------------------------------------------------
module alias_sampler_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,   // weight, random_draw
    input  logic        s_tuser,   // kind
    input  logic        s_tlast,   // last_weight
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // outcome, zero filled
    input  logic [1:0]  m_tuser,   // status
    output int          fail_count,
    output int          pending
);
    import ias_pkg::*;

    typedef struct {
        logic [OUTCOME_W-1:0] outcome;
        status_t              status;
    } sample_word_t;

    sample_word_t     expected_words[$];

    logic [31:0]      weight_mem[MAX_OUTCOMES];
    longint unsigned  share_mem[MAX_OUTCOMES];
    longint unsigned  alias_mem[MAX_OUTCOMES];
    longint unsigned  bound_mem[MAX_OUTCOMES];
    longint unsigned  small_cell[MAX_OUTCOMES];
    longint unsigned  small_share[MAX_OUTCOMES];
    longint unsigned  large_cell[MAX_OUTCOMES];
    longint unsigned  large_share[MAX_OUTCOMES];
    longint unsigned  total_weight;
    int unsigned      set_size;
    longint unsigned  cell_height;
    bit               table_valid;
    bit               set_done;

    initial begin
        fail_count   = 0;
        total_weight = 0;
        set_size     = 0;
        cell_height  = 0;
        table_valid  = 0;
        set_done     = 0;
    end

    assign pending = expected_words.size();

    function automatic longint unsigned wrap(longint unsigned p, longint unsigned n);
        return (p >= n) ? p - n : p;
    endfunction

    function automatic status_t build_alias_table();
        longint unsigned n, h, m, sum, shortfall, id, tot;
        longint unsigned sh, sc, lh, lc, lo_c, lo_s, hi_c, hi_s;
        n = set_size;
        sum = 0;
        sh = 0; sc = 0; lh = 0; lc = 0;
        set_done    = 1;
        table_valid = 0;
        if (n == 0 || total_weight == 0) begin
            return STATUS_ZERO;
        end
        h = longint'(FULL_MASS) / n;
        m = h * n;
        cell_height = h;
        for (int i = 0; i < n; i++) begin
            share_mem[i] = (longint'(weight_mem[i]) * m) / total_weight;
            sum += share_mem[i];
        end
        if (sum < m) begin
            shortfall = m - sum;
            id = 0;
            for (longint unsigned i = 0; i < shortfall; i++) begin
                share_mem[id] += 1;
                id = wrap(id + 1, n);
            end
        end
        for (int k = 0; k < n; k++) begin
            alias_mem[k] = k;
            bound_mem[k] = ((k + 1) * h) & 64'h7fffffff;
        end
        for (int k = 0; k < n; k++) begin
            if (share_mem[k] < h) begin
                small_cell[wrap(sh + sc, n)]  = k;
                small_share[wrap(sh + sc, n)] = share_mem[k];
                sc++;
            end else begin
                large_cell[wrap(lh + lc, n)]  = k;
                large_share[wrap(lh + lc, n)] = share_mem[k];
                lc++;
            end
        end
        while (sc != 0 && lc != 0) begin
            lo_c = small_cell[sh];
            lo_s = small_share[sh];
            hi_c = large_cell[lh];
            hi_s = large_share[lh];
            sh = wrap(sh + 1, n); sc--;
            lh = wrap(lh + 1, n); lc--;
            alias_mem[lo_c] = hi_c;
            bound_mem[lo_c] = (lo_c * h + lo_s) & 64'h7fffffff;
            tot = hi_s + lo_s;
            if (tot > 2 * h) begin
                large_cell[wrap(lh + lc, n)]  = hi_c;
                large_share[wrap(lh + lc, n)] = (tot - h) & 64'hffffffff;
                lc++;
            end else begin
                small_cell[wrap(sh + sc, n)]  = hi_c;
                small_share[wrap(sh + sc, n)] = (tot - h) & 64'hffffffff;
                sc++;
            end
        end
        while (sc != 0) begin
            alias_mem[small_cell[sh]] = small_cell[sh];
            bound_mem[small_cell[sh]] = (small_cell[sh] * h + small_share[sh]) & 64'h7fffffff;
            sh = wrap(sh + 1, n); sc--;
        end
        while (lc != 0) begin
            alias_mem[large_cell[lh]] = large_cell[lh];
            bound_mem[large_cell[lh]] = (large_cell[lh] * h + large_share[lh]) & 64'h7fffffff;
            lh = wrap(lh + 1, n); lc--;
        end
        table_valid = 1;
        return STATUS_OK;
    endfunction

    function automatic void predict_word(bit kind, logic [31:0] weight, bit last,
                                         logic [31:0] draw);
        sample_word_t    w;
        longint unsigned idx;
        w.outcome = '0;
        w.status  = STATUS_OK;
        if (kind == 1'b0) begin
            if (set_done) begin
                set_done     = 0;
                table_valid  = 0;
                set_size     = 0;
                total_weight = 0;
            end
            if (set_size < MAX_OUTCOMES) begin
                weight_mem[set_size] = weight;
                set_size++;
                total_weight += weight;
            end
            if (!last) begin
                return;
            end
            w.status = build_alias_table();
        end else if (!table_valid || cell_height == 0 || set_size == 0) begin
            w.status = STATUS_NOTABLE;
        end else begin
            idx = longint'(draw) / cell_height;
            if (idx >= set_size) begin
                idx = set_size - 1;
            end
            w.outcome = OUTCOME_W'((longint'(draw) < bound_mem[idx]) ? idx : alias_mem[idx]);
        end
        expected_words.push_back(w);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        sample_word_t w;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_word(s_tuser, s_tdata[31:0], s_tlast, s_tdata[63:32]);
            end
            if (m_tvalid && m_tready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word, status", m_tuser, -1);
                end else begin
                    w = expected_words.pop_front();
                    if (m_tdata !== {6'b0, w.outcome}) begin
                        report_mismatch("outcome", m_tdata, w.outcome);
                    end
                    if (m_tuser !== w.status) begin
                        report_mismatch("status", m_tuser, w.status);
                    end
                end
            end
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives loads and samples into the alias-table sampler with random gaps on
// both channels and one long output stall, and reports the verdict of the
// checker.
// ----------------------------------------------------------------------------
module testbench;
    import ias_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    int          fail_count;
    int          pending;
    int          idle_cycles;

    integer_alias_table_sampler_unit u_top (.*);

    alias_sampler_checker u_checker (.*);

    initial begin
        aclk = 0;
    end

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            idle_cycles <= 0;
        end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int rx_count;
        int gap;
        rx_count = 0;
        m_tready = 0;
        wait (aresetn);
        forever begin
            if (rx_count == 100) begin
                gap = 300;
            end else if ((rx_count / 64) % 3 == 0) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, 3);
            end
            if (gap > 0) begin
                m_tready <= 0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            rx_count++;
        end
    end

    task automatic send_word(bit kind, logic [31:0] lo, logic [31:0] hi, bit last);
        int gap;
        gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= kind;
        s_tlast  <= last;
        s_tdata  <= {hi, lo};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic load_weight(logic [31:0] w, bit last);
        send_word(1'b0, w, $urandom, last);
    endtask

    task automatic draw_sample(logic [31:0] d);
        send_word(1'b1, $urandom, d, $urandom_range(0, 1));
    endtask

    function automatic logic [31:0] pick_weight();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hffffffff;
            2: return $urandom_range(0, 15);
            3: return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    task automatic load_set(int n);
        for (int i = 0; i < n; i++) begin
            load_weight(pick_weight(), i == n - 1);
        end
    endtask

    task automatic draw_near_cells(int n);
        logic [31:0] h;
        h = 32'h7fffffff / ((n > MAX_OUTCOMES) ? MAX_OUTCOMES : n);
        case ($urandom_range(0, 3))
            0: draw_sample($urandom);
            1: draw_sample(h * $urandom_range(0, n - 1) + $urandom_range(0, 3) - 2);
            2: draw_sample(h * $urandom_range(0, n - 1) + $urandom_range(0, h));
            default: draw_sample(32'hffffffff - $urandom_range(0, 7));
        endcase
    endtask

    initial begin
        int n;
        s_tvalid    = 0;
        s_tdata     = '0;
        s_tuser     = 0;
        s_tlast     = 0;
        aresetn     = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed part: no table, zero totals, one-cell, two-cell and three-cell sets.
        draw_sample(32'h0);
        draw_sample(32'hffffffff);
        load_weight(32'h0, 1);
        draw_sample(32'h12345678);
        load_weight(32'h0, 0);
        load_weight(32'h0, 1);
        load_weight(32'hffffffff, 1);
        draw_sample(32'h0);
        draw_sample(32'hffffffff);
        load_weight(32'hffffffff, 0);
        load_weight(32'h1, 1);
        draw_sample(32'h0);
        draw_sample(32'h3fffffff);
        draw_sample(32'h7ffffffe);
        draw_sample(32'hffffffff);
        load_weight(32'h0, 0);
        load_weight(32'h5, 0);
        draw_sample(32'h0);
        load_weight(32'h0, 1);
        draw_sample(32'h40000000);
        draw_sample(32'h7fffffff);

        // Random part, mostly small sets followed by samples.
        for (int s = 0; s < 25; s++) begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
            if ($urandom_range(0, 9) == 0) begin
                load_set($urandom_range(1, 3));
                draw_sample($urandom);
            end
            load_set(n);
            repeat ($urandom_range(4, 14)) draw_near_cells(n);
        end

        // A larger set, and a small one after it.
        load_set(200);
        repeat (20) draw_near_cells(200);
        load_set(3);
        repeat (10) draw_near_cells(3);
        s_tvalid <= 0;

        @(posedge aclk);
        wait (pending == 0);
        repeat (100) @(posedge aclk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
